// File: src/cmsc_pkg.sv
// Shared widths, constants and the unit status type for the clock mult/shift block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cmsc_pkg;

    localparam int MASK_W    = 64;
    localparam int FREQ_W    = 32;
    localparam int MULT_W    = 32;
    localparam int SHIFT_W   = 6;
    localparam int DIVISOR_W = 42;

    localparam logic [FREQ_W-1:0]  SCALE_HZ      = 32'd1;
    localparam logic [FREQ_W-1:0]  SCALE_KHZ     = 32'd1000;
    localparam logic [MASK_W-1:0]  TARGET_HZ_SH  = 64'd1000000000 << 32;
    localparam logic [MASK_W-1:0]  TARGET_KHZ_SH = 64'd1000000 << 32;
    localparam logic [MASK_W-1:0]  MAX_SEC       = 64'd600;
    localparam logic [MASK_W-1:0]  FIT_INIT      = {32'hFFFF_FFFF, 32'h0000_0000};
    localparam logic [SHIFT_W-1:0] SHIFT_START   = 6'd32;
    localparam logic [SHIFT_W-1:0] SHIFT_LAST    = 6'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } cmsc_unit_stat_t;

endpackage

`default_nettype wire

// File: src/cmsc_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on cmsc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cmsc_in_if import cmsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] counter_mask;
    logic              khz_units;
    logic [FREQ_W-1:0] frequency;

    modport source (output valid, output counter_mask, output khz_units,
                    output frequency, input ready);
    modport sink   (input valid, input counter_mask, input khz_units,
                    input frequency, output ready);
endinterface

interface cmsc_out_if import cmsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MULT_W-1:0]  multiplier;
    logic [SHIFT_W-1:0] shift_amount;
    logic               div_error;

    modport source (output valid, output multiplier, output shift_amount,
                    output div_error, input ready);
    modport sink   (input valid, input multiplier, input shift_amount,
                    input div_error, output ready);
endinterface

`default_nettype wire

// File: src/cmsc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on cmsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmsc_mul import cmsc_pkg::*; #(
    parameter int W = MULT_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [W-1:0]     a,
    input  wire logic [W-1:0]     b,
    output cmsc_unit_stat_t       stat,
    output logic      [2*W-1:0]   product
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     a_reg;
    logic [2*W-1:0]   prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       sum_next;

    // add the multiplicand into the upper half when the low bit is set
    assign sum_next = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            prod_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                prod_reg <= {{W{1'b0}}, b};
                cnt_reg  <= CNT_W'(W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                prod_reg <= {sum_next, prod_reg[W-1:1]};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = prod_reg;

endmodule

`default_nettype wire

// File: src/cmsc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on cmsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmsc_div import cmsc_pkg::*; #(
    parameter int N = MASK_W,
    parameter int D = DIVISOR_W
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [N-1:0]  dividend,
    input  wire logic [D-1:0]  divisor,
    output cmsc_unit_stat_t    stat,
    output logic      [N-1:0]  quotient
);

    localparam int CNT_W = $clog2(N);

    logic [D-1:0]     div_reg;
    logic [D-1:0]     rem_reg;
    logic [N-1:0]     quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D:0]       trial_next;
    logic [D:0]       diff_next;
    logic             take_next;

    assign trial_next = {rem_reg, quo_reg[N-1]};
    assign diff_next  = trial_next - {1'b0, div_reg};
    assign take_next  = (trial_next >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                div_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                cnt_reg  <= CNT_W'(N - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= take_next ? diff_next[D-1:0] : trial_next[D-1:0];
                quo_reg <= {quo_reg[N-2:0], take_next};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: src/clock_mult_shift_calc.sv
// Clock multiplier/shift calculator: usage
// One request word (counter_mask, khz_units, frequency) on the request channel
// gives one result word (multiplier, shift_amount, div_error) on the result
// channel; both are valid/ready, a word moves when valid and ready are high.
// A request is taken only while no other is in progress; one finished result
// may wait in the output register while the next request is taken.
// A zero frequency skips the arithmetic and loads the error word; otherwise the
// block runs one division and three products for the interval, steps the guard
// bits (one per significant bit of the guard product), runs one division for
// every shift tried and loads the result. The next request can be taken in the
// cycle after the result loads. The work is done by one shared radix-2 divider
// and one bit-serial multiplier.
// A stalled receiver holds the result register; a finished word then waits
// inside until the register frees. Reset (rst_n low, asynchronous) empties
// the result register and returns to idle; no clearing pass follows.
// Depends on cmsc_pkg, cmsc_if, cmsc_mul, cmsc_div.
`timescale 1ns / 1ps
`default_nettype none

module clock_mult_shift_calc import cmsc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cmsc_in_if.sink    request,
    cmsc_out_if.source result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DIV,
        ST_DIV_SEC,
        ST_MUL_INT,
        ST_MUL_T,
        ST_GUARD,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic               khz_reg;
    logic               mask_wide_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [MULT_W-1:0]  mul_a_reg;
    logic [MULT_W-1:0]  mul_b_reg;
    logic               mul_start_reg;
    logic [MASK_W-1:0]  dividend_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic               div_start_reg;
    logic [MULT_W-1:0]  t_reg;
    logic [MASK_W-1:0]  fit_mask_reg;
    logic [MASK_W-1:0]  tgt_reg;
    logic [SHIFT_W-1:0] s_reg;
    logic [MULT_W-1:0]  pend_mult_reg;
    logic [SHIFT_W-1:0] pend_shift_reg;
    logic               pend_err_reg;
    logic               out_valid_reg;
    logic [MULT_W-1:0]  out_mult_reg;
    logic [SHIFT_W-1:0] out_shift_reg;
    logic               out_err_reg;

    cmsc_unit_stat_t    mul_stat;
    cmsc_unit_stat_t    div_stat;
    logic [2*MULT_W-1:0] product;
    logic [MASK_W-1:0]  quotient;
    logic [MASK_W-1:0]  sec_clamped;
    logic [MASK_W-1:0]  half_freq;
    logic               fits;

    cmsc_mul #(.W(MULT_W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .stat    (mul_stat),
        .product (product)
    );

    cmsc_div #(.N(MASK_W), .D(DIVISOR_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        priority if (quotient == '0)
            sec_clamped = MASK_W'(1);
        else if (quotient > MAX_SEC && mask_wide_reg)
            sec_clamped = MAX_SEC;
        else
            sec_clamped = quotient;
    end

    assign half_freq = {{(MASK_W-FREQ_W+1){1'b0}}, freq_reg[FREQ_W-1:1]};
    assign fits      = ((quotient & fit_mask_reg) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            khz_reg        <= 1'b0;
            mask_wide_reg  <= 1'b0;
            freq_reg       <= '0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            mul_start_reg  <= 1'b0;
            dividend_reg   <= '0;
            divisor_reg    <= '0;
            div_start_reg  <= 1'b0;
            t_reg          <= '0;
            fit_mask_reg   <= '0;
            tgt_reg        <= '0;
            s_reg          <= '0;
            pend_mult_reg  <= '0;
            pend_shift_reg <= '0;
            pend_err_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_mult_reg   <= '0;
            out_shift_reg  <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (request.valid)
                    begin
                        khz_reg       <= request.khz_units;
                        mask_wide_reg <= (request.counter_mask[MASK_W-1:32] != '0);
                        freq_reg      <= request.frequency;
                        dividend_reg  <= request.counter_mask - (request.counter_mask >> 3);
                        tgt_reg       <= request.khz_units ? TARGET_KHZ_SH : TARGET_HZ_SH;
                        mul_a_reg     <= request.frequency;
                        mul_b_reg     <= request.khz_units ? SCALE_KHZ : SCALE_HZ;
                        if (request.frequency == '0)
                        begin
                            pend_mult_reg  <= '0;
                            pend_shift_reg <= '0;
                            pend_err_reg   <= 1'b1;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            pend_err_reg  <= 1'b0;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_MUL_DIV;
                        end
                    end
                end
                ST_MUL_DIV:
                begin
                    if (mul_stat.done)
                    begin
                        divisor_reg   <= product[DIVISOR_W-1:0];
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_SEC;
                    end
                end
                ST_DIV_SEC:
                begin
                    if (div_stat.done)
                    begin
                        mul_a_reg     <= sec_clamped[MULT_W-1:0];
                        mul_b_reg     <= khz_reg ? SCALE_KHZ : SCALE_HZ;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_INT;
                    end
                end
                ST_MUL_INT:
                begin
                    if (mul_stat.done)
                    begin
                        mul_a_reg     <= product[MULT_W-1:0];
                        mul_b_reg     <= freq_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_T;
                    end
                end
                ST_MUL_T:
                begin
                    if (mul_stat.done)
                    begin
                        t_reg        <= product[2*MULT_W-1:MULT_W];
                        fit_mask_reg <= FIT_INIT;
                        state_reg    <= ST_GUARD;
                    end
                end
                ST_GUARD:
                begin
                    // drop one guard bit per significant bit of t
                    if (t_reg != '0)
                    begin
                        t_reg        <= t_reg >> 1;
                        fit_mask_reg <= {1'b1, fit_mask_reg[MASK_W-1:1]};
                    end
                    else
                    begin
                        s_reg         <= SHIFT_START;
                        dividend_reg  <= tgt_reg + half_freq;
                        divisor_reg   <= DIVISOR_W'(freq_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (div_stat.done)
                    begin
                        priority if (fits)
                        begin
                            pend_mult_reg  <= quotient[MULT_W-1:0];
                            pend_shift_reg <= s_reg;
                            state_reg      <= ST_DONE;
                        end
                        else if (s_reg == SHIFT_LAST)
                        begin
                            pend_mult_reg  <= quotient[MULT_W-1:0];
                            pend_shift_reg <= '0;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            s_reg         <= s_reg - 1'b1;
                            tgt_reg       <= tgt_reg >> 1;
                            dividend_reg  <= (tgt_reg >> 1) + half_freq;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_mult_reg  <= pend_mult_reg;
                        out_shift_reg <= pend_shift_reg;
                        out_err_reg   <= pend_err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign request.ready       = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.multiplier   = out_mult_reg;
    assign result.shift_amount = out_shift_reg;
    assign result.div_error    = out_err_reg;

`ifndef NO_ASSERTIONS
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV_SEC || state_reg == ST_SEARCH))
        else $error("divider finished outside a division state");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_mult_reg == '0 && out_shift_reg == '0))
        else $error("error word carries a non-zero payload");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_shift_reg <= SHIFT_START))
        else $error("shift amount out of range");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");
`endif

endmodule

`default_nettype wire

// File: tb/sv/clock_mult_shift_calc_tb.sv
// Self-checking bench for clock_mult_shift_calc: drives request words, predicts each
// multiplier/shift word and checks the result channel against it in order.
// Depends on cmsc_pkg, cmsc_if and the block's RTL.
`timescale 1ns / 1ps

module clock_mult_shift_calc_tb;
    import cmsc_pkg::*;

    localparam int          CYCLE_LIMIT   = 3_000_000;
    localparam int          DRAIN_CYCLES  = 2_500;
    localparam int          MAX_REPORTS   = 10;
    localparam int          GAP_MAX       = 17;
    localparam logic [63:0] NS_PER_SEC    = 64'd1_000_000_000;
    localparam logic [63:0] LOW32_MAX     = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [MULT_W-1:0]  multiplier;
        logic [SHIFT_W-1:0] shift_amount;
        logic               div_error;
    } conv_word_t;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   cycle_count;
    int   mismatch_count;

    conv_word_t pending_words[$];

    cmsc_in_if  request_ch ();
    cmsc_out_if result_ch ();

    clock_mult_shift_calc u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int bit_length(input logic [63:0] v);
        int n;
        n = 0;
        while (v != 64'd0)
        begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic conv_word_t predict_mult_shift(input logic [MASK_W-1:0] mask,
                                                     input logic khz,
                                                     input logic [FREQ_W-1:0] freq);
        logic [63:0] scale;
        logic [63:0] sec;
        logic [63:0] product;
        logic [31:0] interval;
        logic [63:0] target;
        logic [63:0] guard_src;
        logic [63:0] quot;
        int          guard;
        int          s;
        bit          fits;
        conv_word_t  w;
        w = '0;
        if (freq == '0)
        begin
            w.div_error = 1'b1;
            return w;
        end
        scale = khz ? 64'(SCALE_KHZ) : 64'(SCALE_HZ);
        sec   = (mask - (mask >> 3)) / scale / {32'd0, freq};
        if (sec == 64'd0)
            sec = 64'd1;
        else if (sec > MAX_SEC && mask > LOW32_MAX)
            sec = MAX_SEC;
        product   = sec * scale;
        interval  = product[31:0];
        target    = NS_PER_SEC / scale;
        guard_src = ({32'd0, interval} * {32'd0, freq}) >> 32;
        guard     = 32 - bit_length(guard_src);
        s         = int'(SHIFT_START);
        fits      = 1'b0;
        quot      = 64'd0;
        while (!fits && s > 0)
        begin
            quot = ((target << s) + {33'd0, freq[31:1]}) / {32'd0, freq};
            if ((quot >> guard) == 64'd0)
                fits = 1'b1;
            else
                s--;
        end
        w.multiplier   = quot[31:0];
        w.shift_amount = s[SHIFT_W-1:0];
        return w;
    endfunction

    // send one request word, optionally after an idle burst
    task automatic send_request(input logic [MASK_W-1:0] mask, input logic khz,
                                input logic [FREQ_W-1:0] freq);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            request_ch.valid = 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
        end
        request_ch.valid        = 1'b1;
        request_ch.counter_mask = mask;
        request_ch.khz_units    = khz;
        request_ch.frequency    = freq;
        do
            @(posedge clk);
        while (!request_ch.ready);
        pending_words.push_back(predict_mult_shift(mask, khz, freq));
        @(negedge clk);
    endtask

    function automatic logic [MASK_W-1:0] ones_mask(input int width);
        if (width >= MASK_W)
            return '1;
        return (64'd1 << width) - 64'd1;
    endfunction

    function automatic logic [FREQ_W-1:0] pick_frequency();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(1, 1000));
            1: return 32'($urandom_range(1000, 100_000_000));
            2: return 32'd1 << $urandom_range(0, 31);
            3: return $urandom | 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_zero_frequency();
        send_request('1, 1'b0, '0);
        send_request('0, 1'b1, '0);
        send_request(64'h0000_0000_FFFF_FFFF, 1'b1, '0);
    endtask

    task automatic test_interval_clamps();
        send_request(64'h0000_0000_0000_00FF, 1'b0, 32'd1_000_000);
        send_request(64'h0000_0000_0000_0007, 1'b1, 32'd1);
        send_request('1, 1'b0, 32'd1);
        send_request('1, 1'b1, 32'd1);
        send_request(64'h0000_0000_FFFF_FFFF, 1'b0, 32'd1);
        send_request(64'h0000_0000_FFFF_FFFF, 1'b1, 32'd1);
        send_request(64'h0000_0001_FFFF_FFFF, 1'b0, 32'd1);
        send_request(64'h0000_0001_0000_0000, 1'b0, 32'd2);
    endtask

    task automatic test_field_extremes();
        send_request('0, 1'b0, 32'd1);
        send_request('0, 1'b1, '1);
        send_request('1, 1'b0, '1);
        send_request('1, 1'b1, '1);
        send_request(64'h8000_0000_0000_0000, 1'b0, 32'h8000_0000);
        send_request(64'h5555_5555_5555_5555, 1'b1, 32'h5555_5555);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'hAAAA_AAAA);
        send_request(ones_mask(56), 1'b0, 32'd24_000_000);
        send_request(ones_mask(32), 1'b1, 32'd19_200);
        send_request(ones_mask(24), 1'b0, 32'd3);
    endtask

    task automatic test_realistic_clocks(input int count);
        repeat (count)
            send_request(ones_mask($urandom_range(1, 64)), 1'($urandom_range(0, 1)),
                         pick_frequency());
    endtask

    task automatic test_random_words(input int count);
        logic [FREQ_W-1:0] freq;
        repeat (count)
        begin
            freq = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
            send_request({$urandom, $urandom}, 1'($urandom_range(0, 1)), freq);
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        test_realistic_clocks(count);
    endtask

    // result side: stall in random bursts while idling is on
    initial
    begin
        result_ch.ready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready = 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
                result_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        conv_word_t got;
        conv_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.multiplier, result_ch.shift_amount, result_ch.div_error};
            if (pending_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: mult %h shift %0d err %b",
                             got.multiplier, got.shift_amount, got.div_error);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: expected mult %h shift %0d err %b, ",
                                  "got mult %h shift %0d err %b"},
                                 want.multiplier, want.shift_amount, want.div_error,
                                 got.multiplier, got.shift_amount, got.div_error);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[clock_mult_shift_calc] ERROR");
            $finish;
        end
    end

    initial
    begin
        cycle_count             = 0;
        mismatch_count          = 0;
        idle_on                 = 1'b1;
        rst_n                   = 1'b0;
        request_ch.valid        = 1'b0;
        request_ch.counter_mask = '0;
        request_ch.khz_units    = 1'b0;
        request_ch.frequency    = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_zero_frequency();
        test_interval_clamps();
        test_field_extremes();
        test_realistic_clocks(150);
        test_random_words(50);
        test_back_to_back(50);

        request_ch.valid = 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[clock_mult_shift_calc] OK");
        else
            $display("[clock_mult_shift_calc] ERROR");
        $finish;
    end

endmodule
